@@ design/mctda_pkg.sv @@
// ----------------------------------------------------------------------------
// mctda_pkg: shared types and constants of the tick divider alarm block
// Holds the channel table geometry, the request and result payloads, the
// table entry layout and the rate divider lookup.
// ----------------------------------------------------------------------------
package mctda_pkg;

	localparam int CHANNELS  = 16;
	localparam int BASE_RATE = 1024;
	localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W    = ADDR_W + 1;
	localparam int DIV_W     = 10;
	localparam int TICK_W    = 10;
	localparam int ALARM_W   = 20;
	localparam logic [ALARM_W-1:0] ALARM_MAX = 20'd999999;

	typedef enum logic [2:0] {
		M_TICK  = 3'd0,
		M_OPEN  = 3'd1,
		M_CLOSE = 3'd2,
		M_RATE  = 3'd3,
		M_WAIT  = 3'd4,
		M_SET   = 3'd5,
		M_GET   = 3'd6,
		M_SLEEP = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		K_DONE    = 3'd0,
		K_ERROR   = 3'd1,
		K_WAKE    = 3'd2,
		K_ALARM   = 3'd3,
		K_SUSPEND = 3'd4,
		K_REPORT  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		W_IDLE  = 2'd0,
		W_SLEEP = 2'd1,
		W_WOKEN = 2'd2
	} waiter_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [3:0]         channel;
		logic [15:0]        owner_id;
		logic [7:0]         frequency;
		logic [7:0]         write_length;
		logic [ALARM_W-1:0] alarm_value;
		logic [ALARM_W-1:0] alarm_interval;
	} req_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [3:0]         target_channel;
		logic [15:0]        target_owner;
		logic [ALARM_W-1:0] prev_value;
		logic [ALARM_W-1:0] old_interval;
		logic               last;
	} res_t;

	// One row of the channel table; all zero is the reset value.
	typedef struct packed {
		logic               open;
		logic [DIV_W-1:0]   divider;
		logic [15:0]        owner;
		logic [1:0]         waiter;
		logic [ALARM_W-1:0] acount;
		logic [ALARM_W-1:0] areload;
	} entry_t;

	// Divider for a power-of-two frequency of at least two.
	function automatic logic [DIV_W-1:0] rate_divider(input logic [7:0] freq);
		logic [DIV_W-1:0] d;
		d = '0;
		for (int i = 1; i < 8; i++) begin
			if (freq == 8'(1 << i)) begin
				d = DIV_W'(BASE_RATE >> i);
			end
		end
		return d;
	endfunction

endpackage

@@ design/mctda_stream_if.sv @@
// ----------------------------------------------------------------------------
// mctda_stream_if: valid/ready channel
// Carries one payload of the given type from a source to a sink.
// ----------------------------------------------------------------------------
interface mctda_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/mctda_mem.sv @@
// ----------------------------------------------------------------------------
// mctda_mem: channel table memory
// One write port and one registered read port; rows never written since
// reset read as zero through a per-row valid bit.
// ----------------------------------------------------------------------------
module mctda_mem (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [mctda_pkg::ADDR_W-1:0] rd_addr,
	output mctda_pkg::entry_t       rd_data,
	input  logic                    wr_en,
	input  logic [mctda_pkg::ADDR_W-1:0] wr_addr,
	input  mctda_pkg::entry_t       wr_data
);
	import mctda_pkg::*;

	entry_t              mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	entry_t              raw_q;
	logic                raw_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			raw_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				raw_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = raw_vld_q ? raw_q : '0;

endmodule

@@ design/multi_channel_tick_divider_alarm.sv @@
// ----------------------------------------------------------------------------
// multi_channel_tick_divider_alarm: table of periodic-interrupt channels
// Keeps the channel table in a memory and answers one request at a time.
// ----------------------------------------------------------------------------
// A non-tick request passes through RD and EX; its result is registered from EX.
// A tick sweeps the rows from zero to the highest opened one and closes with a DONE
//   result (straight to DONE with no slot opened); the once-a-second tick
//   sweeps the rows twice, alarms first, then wakes.
// Output stalls hold the sequencer in EX and DONE.
// Reset: asynchronous; tick count goes to one, no slot opened, table rows
//   read as zero until written.
module multi_channel_tick_divider_alarm (
	input logic clk,
	input logic arst_n,
	mctda_stream_if.sink   request,
	mctda_stream_if.source result
);
	import mctda_pkg::*;

	// Sequencer states: IDLE takes a request, RD reads a table row, EX
	// modifies it and writes it back, DONE emits the closing result of a tick.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_EX   = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                wake_pass_q;  // Tick sweep: 0 alarms, 1 wakes.
	logic [TICK_W-1:0]   tick_q;
	logic                any_q;
	logic [ADDR_W-1:0]   hi_q;
	logic                out_valid_q;
	res_t                out_q;

	entry_t              rd_data;
	entry_t              ex_entry;
	logic                ex_wr;
	logic                ex_emit;
	logic                ex_err;
	res_t                ex_res;
	res_t                done_res;
	logic                out_free;
	logic                accept;
	logic [SLOT_W-1:0]   next_slot;
	logic [SLOT_W-1:0]   req_slot;
	logic                chan_bad;
	logic [ALARM_W-1:0]  acount_dec;
	mode_t               req_mode;
	mode_t               in_mode;

	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;
	assign out_free      = !out_valid_q || result.ready;
	assign result.valid  = out_valid_q;
	assign result.payload = out_q;

	assign in_mode   = mode_t'(request.payload.mode);
	assign req_mode  = mode_t'(req_q.mode);
	assign next_slot = any_q ? (SLOT_W'(hi_q) + SLOT_W'(1)) : '0;
	assign req_slot  = SLOT_W'(req_q.channel);
	assign chan_bad  = (SLOT_W'(req_q.channel) >= SLOT_W'(CHANNELS))
		|| (req_q.channel > 4'(CHANNELS - 1));
	assign acount_dec = rd_data.acount - ALARM_W'(1);

	// The closing result of a tick.
	always_comb begin
		done_res      = '0;
		done_res.kind = K_DONE;
		done_res.last = 1'b1;
	end

	mctda_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == S_RD),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.wr_en   ((state_q == S_EX) && ex_wr && out_free),
		.wr_addr (addr_q),
		.wr_data (ex_entry)
	);

	// Modify step: the row just read, the latched request and the sweep
	// phase give the new row and at most one result.
	always_comb begin
		ex_entry = rd_data;
		ex_wr    = 1'b0;
		ex_emit  = 1'b1;
		ex_err   = 1'b0;
		ex_res   = '0;
		ex_res.last = 1'b1;
		ex_res.kind = K_DONE;
		unique case (req_mode)
			M_TICK: begin
				ex_emit = 1'b0;
				ex_res.last = 1'b0;
				ex_res.target_channel = 4'(addr_q);
				ex_res.target_owner = rd_data.owner;
				if (!wake_pass_q) begin
					if (rd_data.acount != '0) begin
						ex_wr = 1'b1;
						if (acount_dec == '0) begin
							ex_entry.acount  = rd_data.areload;
							ex_entry.areload = '0;
							ex_emit = 1'b1;
							ex_res.kind = K_ALARM;
						end else begin
							ex_entry.acount = acount_dec;
						end
					end
				end else if ((rd_data.divider != '0)
						&& ((tick_q & (rd_data.divider - DIV_W'(1))) == '0)
						&& (rd_data.waiter == W_SLEEP)) begin
					ex_wr = 1'b1;
					ex_entry.waiter = W_WOKEN;
					ex_emit = 1'b1;
					ex_res.kind = K_WAKE;
				end
			end
			M_OPEN: begin
				if (next_slot >= SLOT_W'(CHANNELS)) begin
					ex_err = 1'b1;
				end else begin
					ex_wr = 1'b1;
					ex_entry = '0;
					ex_entry.open = 1'b1;
					ex_entry.divider = DIV_W'(BASE_RATE / 2);
					ex_entry.owner = req_q.owner_id;
					ex_res.target_channel = 4'(next_slot);
					ex_res.target_owner = req_q.owner_id;
				end
			end
			M_CLOSE: begin
				if (chan_bad) begin
					ex_err = 1'b1;
				end else begin
					ex_wr = 1'b1;
					ex_entry = '0;
					ex_res.target_channel = req_q.channel;
				end
			end
			M_RATE: begin
				if (chan_bad || (req_q.write_length < 8'd4) || (req_q.frequency < 8'd2)
						|| (11'(req_q.frequency) > 11'(BASE_RATE))
						|| ((req_q.frequency & (req_q.frequency - 8'd1)) != 8'd0)) begin
					ex_err = 1'b1;
				end else begin
					ex_wr = 1'b1;
					ex_entry.divider = rate_divider(req_q.frequency);
					ex_res.target_channel = req_q.channel;
				end
			end
			M_WAIT: begin
				if (chan_bad || !rd_data.open) begin
					ex_err = 1'b1;
				end else begin
					ex_res.target_channel = req_q.channel;
					if (rd_data.waiter == W_IDLE) begin
						ex_wr = 1'b1;
						ex_entry.waiter = W_SLEEP;
						ex_res.kind = K_SUSPEND;
						ex_res.target_owner = rd_data.owner;
					end else if (rd_data.waiter == W_WOKEN) begin
						ex_wr = 1'b1;
						ex_entry.waiter = W_IDLE;
					end
				end
			end
			M_SET, M_SLEEP: begin
				if (!any_q || (req_q.alarm_value > ALARM_MAX)
						|| ((req_mode == M_SET) && (req_q.alarm_interval > ALARM_MAX))
						|| ((req_mode == M_SLEEP) && ((req_q.alarm_value == '0)
							|| (req_q.alarm_interval != '0)))) begin
					ex_err = 1'b1;
				end else begin
					ex_wr = 1'b1;
					ex_entry.acount  = req_q.alarm_value;
					ex_entry.areload = req_q.alarm_interval;
					ex_res.target_channel = 4'(hi_q);
					ex_res.prev_value   = rd_data.acount;
					ex_res.old_interval = rd_data.areload;
				end
			end
			M_GET: begin
				if (!any_q) begin
					ex_err = 1'b1;
				end else begin
					ex_res.kind = K_REPORT;
					ex_res.target_channel = 4'(hi_q);
					if (rd_data.acount != '0) begin
						ex_res.prev_value   = rd_data.acount;
						ex_res.old_interval = rd_data.areload;
					end
				end
			end
			default: begin
				ex_err = 1'b1;
			end
		endcase
		if (ex_err) begin
			ex_wr  = 1'b0;
			ex_res = '0;
			ex_res.kind = K_ERROR;
			ex_res.last = 1'b1;
		end
	end

	// Request sequencer and the scalar state beside the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_q      <= TICK_W'(1);
			any_q       <= 1'b0;
			hi_q        <= '0;
			wake_pass_q <= 1'b0;
			addr_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_mode)
							M_TICK: begin
								addr_q <= '0;
								if (!any_q) begin
									tick_q  <= tick_q + TICK_W'(1);
									state_q <= S_DONE;
								end else if ((tick_q & TICK_W'(BASE_RATE - 1)) == '0) begin
									wake_pass_q <= 1'b0;
									state_q     <= S_RD;
								end else begin
									wake_pass_q <= 1'b1;
									tick_q      <= tick_q + TICK_W'(1);
									state_q     <= S_RD;
								end
							end
							M_OPEN: begin
								addr_q  <= ADDR_W'(next_slot);
								state_q <= S_RD;
							end
							M_CLOSE, M_RATE, M_WAIT: begin
								addr_q  <= ADDR_W'(request.payload.channel);
								state_q <= S_RD;
							end
							default: begin
								addr_q  <= hi_q;
								state_q <= S_RD;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					if (out_free) begin
						if (req_mode == M_TICK) begin
							if (addr_q == hi_q) begin
								if (!wake_pass_q) begin
									wake_pass_q <= 1'b1;
									tick_q      <= tick_q + TICK_W'(1);
									addr_q      <= '0;
									state_q     <= S_RD;
								end else begin
									state_q <= S_DONE;
								end
							end else begin
								addr_q  <= addr_q + ADDR_W'(1);
								state_q <= S_RD;
							end
						end else begin
							if (!ex_err && (req_mode == M_OPEN)) begin
								any_q  <= 1'b1;
								hi_q   <= ADDR_W'(next_slot);
								tick_q <= TICK_W'(1);
							end
							if (!ex_err && (req_mode == M_CLOSE)) begin
								tick_q <= TICK_W'(1);
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The output register loads a new result whenever the previous one is gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ((state_q == S_EX) && ex_emit) || (state_q == S_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request.payload;
		end
		if ((state_q == S_EX) && out_free && ex_emit) begin
			out_q <= ex_res;
		end else if ((state_q == S_DONE) && out_free) begin
			out_q <= done_res;
		end
	end

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (request.payload.mode != M_TICK) |=> state_q == S_RD)
		else $error("non-tick request did not start a table read");
	a_hi_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> SLOT_W'(hi_q) < SLOT_W'(CHANNELS))
		else $error("highest opened slot beyond the table");
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.kind <= K_REPORT)
		else $error("result kind out of range");
	a_mid_signal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> out_q.kind == K_ALARM || out_q.kind == K_WAKE)
		else $error("non-final result is not a signal");
`endif

endmodule

@@ sim/mctda_checker.sv @@
// ----------------------------------------------------------------------------
// mctda_checker: result predictor and comparator for the tick divider alarm
// Watches both channels, runs its own model of the channel table on every
// accepted request, queues the expected results and compares each result.
// ----------------------------------------------------------------------------
module mctda_checker
	import mctda_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_data,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res_data,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [9:0]  ticks;
	logic        any_open;
	int          top_slot;
	logic        is_open [CHANNELS];
	logic [10:0] divider [CHANNELS];
	logic [15:0] owner   [CHANNELS];
	waiter_t     waiter  [CHANNELS];
	logic [19:0] acount  [CHANNELS];
	logic [19:0] areload [CHANNELS];
	res_t        expected_results[$];

	function automatic res_t make_res(kind_t k, int ch, logic [15:0] own,
			logic [19:0] ov, logic [19:0] oi);
		res_t r;
		r.kind = k;
		r.target_channel = 4'(ch);
		r.target_owner = own;
		r.prev_value = ov;
		r.old_interval = oi;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void wipe(int c);
		is_open[c] = 0;
		divider[c] = 0;
		owner[c] = 0;
		waiter[c] = W_IDLE;
		acount[c] = 0;
		areload[c] = 0;
	endfunction

	task automatic predict_request(input req_t q);
		res_t out[$];
		int span;
		int nxt;
		span = any_open ? top_slot + 1 : 0;
		case (mode_t'(q.mode))
			M_TICK: begin
				if (ticks == 0) begin
					for (int c = 0; c < span; c++) begin
						if (acount[c] != 0) begin
							acount[c]--;
							if (acount[c] == 0) begin
								acount[c] = areload[c];
								areload[c] = 0;
								out.push_back(make_res(K_ALARM, c, owner[c], 0, 0));
							end
						end
					end
				end
				ticks = ticks + 1;
				for (int c = 0; c < span; c++) begin
					if (divider[c] != 0 && (ticks & 10'(divider[c] - 1)) == 0 &&
							waiter[c] == W_SLEEP) begin
						out.push_back(make_res(K_WAKE, c, owner[c], 0, 0));
						waiter[c] = W_WOKEN;
					end
				end
				out.push_back(make_res(K_DONE, 0, 0, 0, 0));
			end
			M_OPEN: begin
				nxt = any_open ? top_slot + 1 : 0;
				if (nxt >= CHANNELS) begin
					out.push_back(make_res(K_ERROR, 0, 0, 0, 0));
				end else begin
					any_open = 1;
					top_slot = nxt;
					wipe(nxt);
					is_open[nxt] = 1;
					divider[nxt] = BASE_RATE / 2;
					owner[nxt] = q.owner_id;
					ticks = 1;
					out.push_back(make_res(K_DONE, nxt, q.owner_id, 0, 0));
				end
			end
			M_CLOSE: begin
				wipe(q.channel);
				ticks = 1;
				out.push_back(make_res(K_DONE, q.channel, 0, 0, 0));
			end
			M_RATE: begin
				if (q.write_length < 4 || q.frequency < 2 ||
						(q.frequency & (q.frequency - 8'd1)) != 0) begin
					out.push_back(make_res(K_ERROR, 0, 0, 0, 0));
				end else begin
					divider[q.channel] = BASE_RATE / q.frequency;
					out.push_back(make_res(K_DONE, q.channel, 0, 0, 0));
				end
			end
			M_WAIT: begin
				if (!is_open[q.channel]) begin
					out.push_back(make_res(K_ERROR, 0, 0, 0, 0));
				end else if (waiter[q.channel] == W_IDLE) begin
					waiter[q.channel] = W_SLEEP;
					out.push_back(make_res(K_SUSPEND, q.channel, owner[q.channel], 0, 0));
				end else begin
					if (waiter[q.channel] == W_WOKEN) waiter[q.channel] = W_IDLE;
					out.push_back(make_res(K_DONE, q.channel, 0, 0, 0));
				end
			end
			M_GET: begin
				if (!any_open) begin
					out.push_back(make_res(K_ERROR, 0, 0, 0, 0));
				end else if (acount[top_slot] == 0) begin
					out.push_back(make_res(K_REPORT, top_slot, 0, 0, 0));
				end else begin
					out.push_back(make_res(K_REPORT, top_slot, 0, acount[top_slot],
						areload[top_slot]));
				end
			end
			default: begin
				// Set alarm and sleep share the store path; sleep is stricter.
				if (!any_open || q.alarm_value > ALARM_MAX || q.alarm_interval > ALARM_MAX ||
						(q.mode == M_SLEEP && (q.alarm_value == 0 || q.alarm_interval != 0))) begin
					out.push_back(make_res(K_ERROR, 0, 0, 0, 0));
				end else begin
					out.push_back(make_res(K_DONE, top_slot, 0, acount[top_slot],
						areload[top_slot]));
					acount[top_slot] = q.alarm_value;
					areload[top_slot] = q.alarm_interval;
				end
			end
		endcase
		out[out.size() - 1].last = 1'b1;
		foreach (out[i]) expected_results.push_back(out[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			ticks = 1;
			any_open = 0;
			top_slot = 0;
			for (int c = 0; c < CHANNELS; c++) wipe(c);
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, res_data);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (res_data.kind !== want.kind ||
							res_data.target_channel !== want.target_channel ||
							res_data.target_owner !== want.target_owner ||
							res_data.prev_value !== want.prev_value ||
							res_data.old_interval !== want.old_interval ||
							res_data.last !== want.last) begin
						$display("%0t: result differs, expected %p, actual %p",
							$time, want, res_data);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready) predict_request(req_data);
			pending = expected_results.size();
		end
	end
endmodule

@@ sim/multi_channel_tick_divider_alarm_test.sv @@
// ----------------------------------------------------------------------------
// multi_channel_tick_divider_alarm_test: stimulus and verdict
// Drives directed and random requests into the channel table under varying
// source and sink idling, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module multi_channel_tick_divider_alarm_test;
	import mctda_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   pending;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   quiet_cycles = 0;

	// A tick with full table and a pile of alarms can emit up to 33 results, each of
	// which may stall, so a long quiet stretch means a hang.
	localparam int QUIET_LIMIT = 20000;

	mctda_stream_if #(.payload_t(req_t)) request ();
	mctda_stream_if #(.payload_t(res_t)) result ();

	multi_channel_tick_divider_alarm uut (
		.clk(clk), .arst_n(arst_n), .request(request), .result(result)
	);

	mctda_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.req_valid(request.valid), .req_ready(request.ready), .req_data(request.payload),
		.res_valid(result.valid), .res_ready(result.ready), .res_data(result.payload),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// The sink side stalls at random according to the current phase.
	always @(negedge clk) begin
		result.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: any cycle without a request or a result accepted counts.
	always @(posedge clk) begin
		if ((request.valid && request.ready) || (result.valid && result.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic req_t blank_request(mode_t m);
		req_t q;
		q = '0;
		q.mode = m;
		q.write_length = 8'd4;
		return q;
	endfunction

	// Sends one request: optional idle gap, then hold valid until accepted.
	// Valid stays high on return so that requests can follow back to back.
	task automatic send(input req_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			request.valid <= 1'b0;
			@(negedge clk);
		end
		request.payload <= q;
		request.valid <= 1'b1;
		do @(posedge clk); while (!request.ready);
		@(negedge clk);
	endtask

	// Power of two frequency mostly valid, sometimes malformed.
	function automatic logic [7:0] pick_frequency();
		if ($urandom_range(3) == 0) return 8'($urandom_range(255));
		return 8'(1 << $urandom_range(1, 7));
	endfunction

	function automatic logic [19:0] pick_alarm();
		case ($urandom_range(5))
			0: return 20'd0;
			1: return 20'($urandom_range(1048575));
			2: return 20'd999999;
			default: return 20'($urandom_range(1, 3));
		endcase
	endfunction

	function automatic req_t random_request();
		req_t q;
		int pick;
		q = '0;
		q.channel = 4'($urandom_range(15));
		q.owner_id = 16'($urandom_range(65535));
		q.frequency = pick_frequency();
		q.write_length = ($urandom_range(7) == 0) ? 8'($urandom_range(3))
			: 8'($urandom_range(4, 255));
		q.alarm_value = pick_alarm();
		q.alarm_interval = ($urandom_range(2) == 0) ? 20'd0 : pick_alarm();
		pick = $urandom_range(99);
		// Ticks dominate so that wakes come up often.
		if (pick < 40)      q.mode = M_TICK;
		else if (pick < 48) q.mode = M_OPEN;
		else if (pick < 51) q.mode = M_CLOSE;
		else if (pick < 60) q.mode = M_RATE;
		else if (pick < 75) q.mode = M_WAIT;
		else if (pick < 84) q.mode = M_SET;
		else if (pick < 92) q.mode = M_GET;
		else                q.mode = M_SLEEP;
		return q;
	endfunction

	// Holds the source idle until every expected result has come.
	task automatic drain();
		request.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		req_t q;
		request.valid = 1'b0;
		request.payload = '0;
		result.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: alarm commands with nothing open, then the table.
		send_idle_pct = 36;
		recv_idle_pct = 74;
		send(blank_request(M_GET));
		send(blank_request(M_SET));
		send(blank_request(M_SLEEP));
		send(blank_request(M_TICK));
		q = blank_request(M_OPEN);
		q.owner_id = 16'hFFFF;
		send(q);
		q = blank_request(M_WAIT);
		send(q);
		q = blank_request(M_RATE);
		q.frequency = 8'd128;
		q.write_length = 8'd255;
		send(q);
		q.frequency = 8'd3;
		send(q);
		q.frequency = 8'd2;
		q.write_length = 8'd3;
		send(q);
		q.frequency = 8'd255;
		q.write_length = 8'd4;
		q.channel = 4'd15;
		send(q);
		send(blank_request(M_TICK));
		send(blank_request(M_TICK));
		q = blank_request(M_WAIT);
		send(q);
		send(q);
		q = blank_request(M_SET);
		q.alarm_value = 20'd999999;
		q.alarm_interval = 20'd999999;
		send(q);
		q.alarm_value = 20'hFFFFF;
		send(q);
		send(blank_request(M_GET));
		q = blank_request(M_SLEEP);
		q.alarm_value = 20'd1;
		send(q);
		q.alarm_interval = 20'd5;
		send(q);
		q = blank_request(M_CLOSE);
		q.channel = 4'd15;
		send(q);
		q = blank_request(M_WAIT);
		q.channel = 4'd15;
		send(q);
		drain();

		// Fill the table past its end so the full case comes up.
		for (int i = 0; i < CHANNELS + 1; i++) begin
			q = blank_request(M_OPEN);
			q.owner_id = 16'($urandom_range(65535));
			send(q);
		end
		// Arm a one second alarm with reload, then sweep the full table a few times.
		q = blank_request(M_SET);
		q.alarm_value = 20'd1;
		q.alarm_interval = 20'd1;
		send(q);
		for (int i = 0; i < 8; i++) send(blank_request(M_TICK));

		// Random part in three idling phases.
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 36 : (p == 1) ? 74 : 0;
			recv_idle_pct = (p == 0) ? 74 : (p == 1) ? 36 : 0;
			for (int i = 0; i < 144; i++) begin
				send(random_request());
				if (i == 72) drain();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ multi_channel_tick_divider_alarm.f @@
design/mctda_pkg.sv
design/mctda_stream_if.sv
design/mctda_mem.sv
design/multi_channel_tick_divider_alarm.sv
sim/mctda_checker.sv
sim/multi_channel_tick_divider_alarm_test.sv
